// ----- sv/hall_tachometer_rpm_unit_macros.svh -----
// Assertion macros for the hall tachometer rpm unit.
`ifndef HALL_TACHOMETER_RPM_UNIT_MACROS_SVH
`define HALL_TACHOMETER_RPM_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HTR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htr assertion failed");

// Next-cycle implication, disabled in reset.
`define HTR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htr assertion failed");

`endif

// ----- sv/htr_pkg.sv -----
// Types and constants shared by the hall tachometer rpm unit.
package htr_pkg;

  localparam int TIME_W = 32;
  localparam int SPAN_W = 6;
  localparam int CPR_W  = 8;
  localparam int CFG_W  = 32;
  localparam int RPM_W  = 40;

  localparam logic [CPR_W-1:0]  CPR_RST     = 8'd1;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd3000000;
  // 60e6 us per minute, times 256 for 8 fraction bits
  localparam logic [RPM_W-1:0]  US_MIN_FRAC = 40'd15360000000;

  typedef enum logic [1:0] {
    FUNC_PULSE = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } htr_func_t;

  typedef enum logic [0:0] {
    REG_CPR     = 1'b0,
    REG_TIMEOUT = 1'b1
  } htr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NEW,
    ST_RD_OLD,
    ST_SPAN,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } htr_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } htr_div_sts_t;

endpackage

// ----- sv/htr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module htr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [htr_pkg::RPM_W-1:0]     num,
  input  logic [htr_pkg::RPM_W-1:0]     den,
  output logic [htr_pkg::RPM_W-1:0]     quot,
  output htr_pkg::htr_div_sts_t         sts
);

  localparam int W  = htr_pkg::RPM_W;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign quot     = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ----- sv/hall_tachometer_rpm_unit.sv -----
// Hall tachometer rpm unit: pulse ring, bit-serial multiply, serial divide.
// Pulse and clear items give no result.
// A stopped query goes straight to the result; on a zero span it ends after 2 ring
// reads and the span; else 8 shift-add steps and 40 divider steps follow.
// One item at a time; the next is taken once the result sits in the output register.
// Synchronous reset restores register defaults and empties the ring at once.
`include "hall_tachometer_rpm_unit_macros.svh"

module hall_tachometer_rpm_unit #(
  parameter int DEPTH = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [htr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [htr_pkg::TIME_W-1:0]     in_time_us,
  input  logic [htr_pkg::SPAN_W-1:0]     in_sample_span,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [htr_pkg::RPM_W-1:0]      out_rpm_fixed,
  output logic                           out_stopped
);

  localparam int TW  = htr_pkg::TIME_W;
  localparam int SW  = htr_pkg::SPAN_W;
  localparam int RW  = htr_pkg::RPM_W;
  localparam int CPW = htr_pkg::CPR_W;
  localparam int IW  = $clog2(DEPTH);
  localparam int VCW = $clog2(DEPTH + 1);
  localparam int XW  = ((IW > SW) ? IW : SW) + 1;
  localparam int MCW = $clog2(CPW);

  htr_pkg::htr_state_t   state_r, state_nxt;
  htr_pkg::htr_div_sts_t div_sts;

  logic [CPW-1:0] cpr_r;
  logic [TW-1:0]  timeout_r;
  logic [IW-1:0]  wr_idx_r;
  logic [VCW-1:0] vcnt_r;
  logic [TW-1:0]  last_r;
  logic [TW-1:0]  ring_mem [DEPTH];
  logic [IW-1:0]  rd_addr_r;
  logic [IW-1:0]  old_addr_r;
  logic [TW-1:0]  rd_data_r;
  logic [TW-1:0]  newest_r;
  logic [SW-1:0]  n_r;
  logic [SW-1:0]  n_sh_r;
  logic [RW-1:0]  k_sh_r;
  logic [CPW-1:0] cpr_sh_r;
  logic [RW-1:0]  span_sh_r;
  logic [RW-1:0]  num_r;
  logic [RW-1:0]  den_r;
  logic [MCW-1:0] mcnt_r;
  logic [RW-1:0]  res_rpm_r;
  logic           res_stop_r;
  logic           out_valid_r;
  logic [RW-1:0]  out_rpm_r;
  logic           out_stopped_r;

  logic           in_xfer;
  logic           pulse_we;
  logic           div_start;
  logic           out_load;
  logic [TW-1:0]  elapsed;
  logic           stop_now;
  logic [TW-1:0]  span_w;
  logic [XW-1:0]  n_x;
  logic [XW-1:0]  new_x;
  logic [XW-1:0]  old_x;
  logic [SW-1:0]  n_sel;
  logic [IW-1:0]  newest_addr;
  logic [IW-1:0]  oldest_addr;
  logic [RW-1:0]  div_quot;

  assign in_xfer  = in_valid && in_ready;
  assign pulse_we = in_xfer && (in_func == htr_pkg::FUNC_PULSE);
  assign elapsed  = in_time_us - last_r;
  assign stop_now = (vcnt_r < VCW'(2)) || (elapsed > timeout_r);
  assign span_w   = newest_r - rd_data_r;

  always_comb begin
    n_x = XW'(in_sample_span);
    if (n_x >= XW'(vcnt_r)) n_x = XW'(vcnt_r) - 1'b1;
    if (n_x >= XW'(DEPTH)) n_x = XW'(DEPTH - 1);
    n_sel       = n_x[SW-1:0];
    newest_addr = (wr_idx_r == '0) ? IW'(DEPTH - 1) : wr_idx_r - 1'b1;
    new_x       = XW'(newest_addr);
    old_x       = (new_x >= n_x) ? new_x - n_x : new_x + XW'(DEPTH) - n_x;
    oldest_addr = old_x[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= htr_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      htr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_func == htr_pkg::FUNC_QUERY)) begin
          state_nxt = stop_now ? htr_pkg::ST_DONE : htr_pkg::ST_RD_NEW;
        end
      end
      htr_pkg::ST_RD_NEW: state_nxt = htr_pkg::ST_RD_OLD;
      htr_pkg::ST_RD_OLD: state_nxt = htr_pkg::ST_SPAN;
      htr_pkg::ST_SPAN: begin
        state_nxt = (span_w == '0) ? htr_pkg::ST_DONE : htr_pkg::ST_MUL;
      end
      htr_pkg::ST_MUL: begin
        if (mcnt_r == MCW'(CPW - 1)) state_nxt = htr_pkg::ST_DIV_GO;
      end
      htr_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = htr_pkg::ST_DIV;
      end
      htr_pkg::ST_DIV: begin
        if (div_sts.done) state_nxt = htr_pkg::ST_DONE;
      end
      htr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = htr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r       <= htr_pkg::CPR_RST;
      timeout_r   <= htr_pkg::TIMEOUT_RST;
      wr_idx_r    <= '0;
      vcnt_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (htr_pkg::htr_reg_t'(cfg_index))
          htr_pkg::REG_CPR:     cpr_r     <= cfg_data[CPW-1:0];
          htr_pkg::REG_TIMEOUT: timeout_r <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        case (htr_pkg::htr_func_t'(in_func))
          htr_pkg::FUNC_PULSE: begin
            wr_idx_r <= (wr_idx_r == IW'(DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
            if (vcnt_r != VCW'(DEPTH)) vcnt_r <= vcnt_r + 1'b1;
            last_r <= in_time_us;
          end
          htr_pkg::FUNC_CLEAR: begin
            wr_idx_r <= '0;
            vcnt_r   <= '0;
            last_r   <= '0;
          end
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_we) ring_mem[wr_idx_r] <= in_time_us;
    rd_data_r <= ring_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      htr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          rd_addr_r  <= newest_addr;
          old_addr_r <= oldest_addr;
          n_r        <= n_sel;
          res_rpm_r  <= '0;
          res_stop_r <= 1'b1;
        end
      end
      htr_pkg::ST_RD_NEW: rd_addr_r <= old_addr_r;
      htr_pkg::ST_RD_OLD: newest_r <= rd_data_r;
      htr_pkg::ST_SPAN: begin
        res_rpm_r  <= '0;
        res_stop_r <= 1'b0;
        span_sh_r  <= RW'(span_w);
        cpr_sh_r   <= (cpr_r == '0) ? CPW'(1) : cpr_r;
        n_sh_r     <= n_r;
        k_sh_r     <= htr_pkg::US_MIN_FRAC;
        num_r      <= '0;
        den_r      <= '0;
        mcnt_r     <= '0;
      end
      htr_pkg::ST_MUL: begin
        if (cpr_sh_r[0]) den_r <= den_r + span_sh_r;
        if (n_sh_r[0]) num_r <= num_r + k_sh_r;
        cpr_sh_r  <= cpr_sh_r >> 1;
        n_sh_r    <= n_sh_r >> 1;
        span_sh_r <= span_sh_r << 1;
        k_sh_r    <= k_sh_r << 1;
        mcnt_r    <= mcnt_r + 1'b1;
      end
      htr_pkg::ST_DIV: begin
        if (div_sts.done) res_rpm_r <= div_quot;
      end
      htr_pkg::ST_DONE: begin
        if (out_load) begin
          out_rpm_r     <= res_rpm_r;
          out_stopped_r <= res_stop_r;
        end
      end
      default: ;
    endcase
  end

  htr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  assign out_valid     = out_valid_r;
  assign out_rpm_fixed = out_rpm_r;
  assign out_stopped   = out_stopped_r;

  `HTR_ASSERT_IMP(a_vcnt_bound, clk, rst_n, 1'b1, vcnt_r <= VCW'(DEPTH))
  `HTR_ASSERT_IMP(a_stop_zero, clk, rst_n, out_valid_r && out_stopped_r, out_rpm_r == '0)
  `HTR_ASSERT_IMP(a_div_owner, clk, rst_n, div_sts.busy || div_sts.done, state_r == htr_pkg::ST_DIV)
  `HTR_ASSERT_NXT(a_div_done, clk, rst_n, (state_r == htr_pkg::ST_DIV) && div_sts.done, state_r == htr_pkg::ST_DONE)

endmodule
